// File: hw/rtl/zstf_pkg.sv
// zstf_pkg: shared types and constants for the zero-sum triplet finder
// used by zstf_ctrl, zstf_datapath and zero_sum_triplet_finder_top; no dependencies
package zstf_pkg;

    localparam int DATA_W = 32;
    localparam int KIND_W = 2;

    // transaction kinds on the request channel
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SCAN,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_INIT,
        ST_LOOP,
        ST_CMP,
        ST_LSKIP,
        ST_LCMP,
        ST_RSKIP,
        ST_RCMP,
        ST_FSKIP,
        ST_FCMP,
        ST_FCHK,
        ST_EMIT_HIT,
        ST_EMIT_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic ins_drop;
        logic ins_start;
        logic ins_rd;
        logic ins_shift;
        logic ins_put;
        logic scan_init;
        logic fval_load;
        logic left_inc;
        logic right_dec;
        logic match;
        logic first_inc;
        logic rd_first;
        logic set_done;
        logic rewind;
        logic emit;
        logic emit_found;
    } cmd_t;

    typedef struct packed {
        logic   full;
        logic   lt3;
        logic   pos_zero;
        logic   pos_one;
        logic   shift_gt;
        logic   sum_neg;
        logic   sum_pos;
        logic   lt;
        logic   l_eq;
        logic   r_eq;
        logic   f_lt_n;
        logic   f_eq;
        logic   f_end;
        phase_t phase;
        logic   out_busy;
    } status_t;

endpackage

// File: hw/rtl/zstf_ctrl.sv
// zstf_ctrl: sequencer for sorted insertion and the two-pointer triplet scan
// depends on zstf_pkg; drives zstf_datapath through cmd_t, reads status_t
module zstf_ctrl
    import zstf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [KIND_W-1:0]   kind,
    input  status_t             stat,
    output cmd_t                cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (kind == KIND_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (kind == KIND_LOAD)
                    begin
                        if (stat.full)
                        begin
                            cmd.ins_drop = 1'b1;
                        end
                        else
                        begin
                            cmd.ins_start = 1'b1;
                            state_next    = ST_INS_CHK;
                        end
                    end
                    else if (kind == KIND_NEXT)
                    begin
                        if (stat.phase == PH_DONE)
                        begin
                            state_next = ST_EMIT_DONE;
                        end
                        else if (stat.phase == PH_SCAN)
                        begin
                            state_next = ST_LOOP;
                        end
                        else if (stat.lt3)
                        begin
                            cmd.set_done = 1'b1;
                            state_next   = ST_EMIT_DONE;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = ST_INIT;
                        end
                    end
                end
            end
            ST_INS_CHK:
            begin
                if (stat.pos_zero)
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (stat.shift_gt)
                begin
                    // move the larger entry up, fetch the next one below
                    cmd.ins_shift = 1'b1;
                    state_next    = stat.pos_one ? ST_INS_CHK : ST_INS_CMP;
                end
                else
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_INIT:
            begin
                cmd.fval_load = 1'b1;
                state_next    = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (stat.lt)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    cmd.first_inc = 1'b1;
                    state_next    = ST_FSKIP;
                end
            end
            ST_CMP:
            begin
                if (stat.sum_neg)
                begin
                    cmd.left_inc = 1'b1;
                    state_next   = ST_LOOP;
                end
                else if (stat.sum_pos)
                begin
                    cmd.right_dec = 1'b1;
                    state_next    = ST_LOOP;
                end
                else
                begin
                    cmd.match  = 1'b1;
                    state_next = ST_LSKIP;
                end
            end
            ST_LSKIP:
            begin
                state_next = stat.lt ? ST_LCMP : ST_RSKIP;
            end
            ST_LCMP:
            begin
                if (stat.l_eq)
                begin
                    cmd.left_inc = 1'b1;
                    state_next   = ST_LSKIP;
                end
                else
                begin
                    state_next = ST_RSKIP;
                end
            end
            ST_RSKIP:
            begin
                state_next = stat.lt ? ST_RCMP : ST_EMIT_HIT;
            end
            ST_RCMP:
            begin
                if (stat.r_eq)
                begin
                    cmd.right_dec = 1'b1;
                    state_next    = ST_RSKIP;
                end
                else
                begin
                    state_next = ST_EMIT_HIT;
                end
            end
            ST_FSKIP:
            begin
                if (stat.f_lt_n)
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = ST_FCMP;
                end
                else
                begin
                    state_next = ST_FCHK;
                end
            end
            ST_FCMP:
            begin
                if (stat.f_eq)
                begin
                    cmd.first_inc = 1'b1;
                    state_next    = ST_FSKIP;
                end
                else
                begin
                    cmd.fval_load = 1'b1;
                    state_next    = ST_FCHK;
                end
            end
            ST_FCHK:
            begin
                if (stat.f_end)
                begin
                    cmd.set_done = 1'b1;
                    state_next   = ST_EMIT_DONE;
                end
                else
                begin
                    cmd.rewind = 1'b1;
                    state_next = ST_LOOP;
                end
            end
            ST_EMIT_HIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_found = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/zstf_datapath.sv
// zstf_datapath: sorted store memory, scan pointers, sum compare and result register
// depends on zstf_pkg; commanded by zstf_ctrl
module zstf_datapath
    import zstf_pkg::*;
#(
    parameter int STORE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   stat,
    input  logic signed [DATA_W-1:0]  element,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic                      found,
    output logic signed [DATA_W-1:0]  low_value,
    output logic signed [DATA_W-1:0]  mid_value,
    output logic signed [DATA_W-1:0]  high_value,
    output logic                      done_res,
    output logic                      overflowed
);

    localparam int IW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = VALUE_WIDTH + 2;

    logic signed [VALUE_WIDTH-1:0] store_mem [STORE_DEPTH];

    logic signed [VALUE_WIDTH-1:0] rd_a_reg;
    logic signed [VALUE_WIDTH-1:0] rd_b_reg;
    logic signed [VALUE_WIDTH-1:0] v_reg;
    logic signed [VALUE_WIDTH-1:0] fval_reg;
    logic signed [VALUE_WIDTH-1:0] t0_reg;
    logic signed [VALUE_WIDTH-1:0] t1_reg;
    logic signed [VALUE_WIDTH-1:0] t2_reg;
    logic signed [VALUE_WIDTH-1:0] low_reg;
    logic signed [VALUE_WIDTH-1:0] mid_reg;
    logic signed [VALUE_WIDTH-1:0] high_reg;
    logic                          found_reg;
    logic                          done_reg;
    logic                          ovf_reg;
    logic [IW-1:0]                 pos_reg;
    logic [IW-1:0]                 pos_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] first_reg, first_next;
    logic [IW-1:0] left_reg, left_next;
    logic [IW-1:0] right_reg, right_next;
    phase_t        phase_reg, phase_next;
    logic          drop_reg, drop_next;
    logic          out_valid_reg, out_valid_next;

    logic [IW-1:0]                 addr_a;
    logic [IW-1:0]                 addr_b;
    logic                          mem_we;
    logic signed [VALUE_WIDTH-1:0] wr_data;
    logic signed [VALUE_WIDTH-1:0] element_v;
    logic signed [SW-1:0]          sum;

    assign element_v = element[VALUE_WIDTH-1:0];

    // port a serves insertion and the left pointer, port b the right and first pointers
    always_comb
    begin
        if (cmd.ins_rd)
        begin
            addr_a = pos_reg - IW'(1);
        end
        else if (cmd.ins_shift)
        begin
            addr_a = pos_reg - IW'(2);
        end
        else
        begin
            addr_a = left_reg;
        end
        if (cmd.scan_init)
        begin
            addr_b = '0;
        end
        else if (cmd.rd_first)
        begin
            addr_b = first_reg[IW-1:0];
        end
        else
        begin
            addr_b = right_reg;
        end
    end

    assign mem_we  = cmd.ins_shift | cmd.ins_put;
    assign wr_data = cmd.ins_shift ? rd_a_reg : v_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[pos_reg] <= wr_data;
        end
        rd_a_reg <= store_mem[addr_a];
        rd_b_reg <= store_mem[addr_b];
    end

    assign pos_next = cmd.ins_start ? count_reg[IW-1:0] :
                      cmd.ins_shift ? pos_reg - IW'(1) : pos_reg;

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.ins_start)
        begin
            v_reg <= element_v;
        end
        if (cmd.fval_load)
        begin
            fval_reg <= rd_b_reg;
        end
        if (cmd.match)
        begin
            t0_reg <= fval_reg;
            t1_reg <= rd_a_reg;
            t2_reg <= rd_b_reg;
        end
        if (cmd.emit)
        begin
            found_reg <= cmd.emit_found;
            low_reg   <= cmd.emit_found ? t0_reg : '0;
            mid_reg   <= cmd.emit_found ? t1_reg : '0;
            high_reg  <= cmd.emit_found ? t2_reg : '0;
            done_reg  <= !cmd.emit_found;
            ovf_reg   <= drop_reg;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        first_next     = first_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        phase_next     = phase_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg & !res_ready;
        if (cmd.clear)
        begin
            count_next = '0;
            drop_next  = 1'b0;
            phase_next = PH_IDLE;
        end
        if (cmd.ins_drop)
        begin
            drop_next  = 1'b1;
            phase_next = PH_IDLE;
        end
        if (cmd.ins_start)
        begin
            phase_next = PH_IDLE;
        end
        if (cmd.ins_put)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.scan_init)
        begin
            first_next = '0;
            left_next  = IW'(1);
            right_next = IW'(count_reg - CW'(1));
            phase_next = PH_SCAN;
        end
        if (cmd.set_done)
        begin
            phase_next = PH_DONE;
        end
        if (cmd.left_inc || cmd.match)
        begin
            left_next = left_reg + IW'(1);
        end
        if (cmd.right_dec || cmd.match)
        begin
            right_next = right_reg - IW'(1);
        end
        if (cmd.first_inc)
        begin
            first_next = first_reg + CW'(1);
        end
        if (cmd.rewind)
        begin
            left_next  = IW'(first_reg + CW'(1));
            right_next = IW'(count_reg - CW'(1));
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            first_reg     <= '0;
            left_reg      <= IW'(1);
            right_reg     <= '0;
            phase_reg     <= PH_IDLE;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            first_reg     <= first_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            phase_reg     <= phase_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sum = SW'(fval_reg) + SW'(rd_a_reg) + SW'(rd_b_reg);

    always_comb
    begin
        stat.full     = (count_reg == CW'(STORE_DEPTH));
        stat.lt3      = (count_reg < CW'(3));
        stat.pos_zero = (pos_reg == '0);
        stat.pos_one  = (pos_reg == IW'(1));
        stat.shift_gt = (rd_a_reg > v_reg);
        stat.sum_neg  = (sum < 0);
        stat.sum_pos  = (sum > 0);
        stat.lt       = (left_reg < right_reg);
        stat.l_eq     = (rd_a_reg == t1_reg);
        stat.r_eq     = (rd_b_reg == t2_reg);
        stat.f_lt_n   = (first_reg < count_reg);
        stat.f_eq     = (rd_b_reg == fval_reg);
        stat.f_end    = ((CW+1)'(first_reg) + (CW+1)'(2) >= (CW+1)'(count_reg));
        stat.phase    = phase_reg;
        stat.out_busy = out_valid_reg & !res_ready;
    end

    assign res_valid  = out_valid_reg;
    assign found      = found_reg;
    assign low_value  = DATA_W'(low_reg);
    assign mid_value  = DATA_W'(mid_reg);
    assign high_value = DATA_W'(high_reg);
    assign done_res   = done_reg;
    assign overflowed = ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STORE_DEPTH))
        else $error("store count above depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !res_ready))
        else $error("result register overwritten while stalled");

    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (low_reg <= mid_reg && mid_reg <= high_reg))
        else $error("triplet not in ascending order");

    a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg)
            |-> (SW'(low_reg) + SW'(mid_reg) + SW'(high_reg) == SW'(0)))
        else $error("returned triplet does not sum to zero");
`endif

endmodule

// File: hw/rtl/zero_sum_triplet_finder_top.sv
// zero_sum_triplet_finder_top: top level of the zero-sum triplet finder
// depends on zstf_pkg, zstf_ctrl and zstf_datapath
//
// request channel (req_valid/req_ready, kind, element): kind clear empties the
// store and the drop flag, kind load inserts element at its sorted place, kind
// next asks for the next unique zero-sum triplet. kind 3 is ignored.
// result channel (res_valid/res_ready): one transaction per next request with
// found, the three values in ascending order, done_res and overflowed.
// load shifts each stored entry greater than the new value up by one place and
// then writes the new value into the gap, all through one write port.
// a next request on an exhausted scan or on fewer than three values goes
// straight to a done result. otherwise it starts a fresh scan if none is under
// way, then steps the pointers, skips duplicates, advances the first pointer
// past repeated first values and hands over each match; a whole scan of n
// values is on the order of n*n/2 pointer steps.
// req_ready is high only between transactions; loads and clears keep being
// taken while a result waits in the output register. a new result waits in
// the sequencer until a stalled one has been taken.
// reset empties the store and sets the scan back to the first triplet.
module zero_sum_triplet_finder_top
    import zstf_pkg::*;
#(
    parameter int STORE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic [KIND_W-1:0]         kind,
    input  logic signed [DATA_W-1:0]  element,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic                      found,
    output logic signed [DATA_W-1:0]  low_value,
    output logic signed [DATA_W-1:0]  mid_value,
    output logic signed [DATA_W-1:0]  high_value,
    output logic                      done_res,
    output logic                      overflowed
);

    cmd_t    cmd;
    status_t stat;

    zstf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .kind      (kind),
        .stat      (stat),
        .cmd       (cmd)
    );

    zstf_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .element    (element),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .found      (found),
        .low_value  (low_value),
        .mid_value  (mid_value),
        .high_value (high_value),
        .done_res   (done_res),
        .overflowed (overflowed)
    );

endmodule

// File: dv/tb_zero_sum_triplet_finder_top.sv
`timescale 1ns / 1ps
// tb_zero_sum_triplet_finder_top: self-checking testbench for the zero-sum triplet finder
// predicts every result with a sorted-store and two-pointer scan model; needs zstf_pkg and the rtl
module tb_zero_sum_triplet_finder_top
    import zstf_pkg::*;
();

    localparam int STORE_DEPTH    = 64;
    localparam int VALUE_WIDTH    = 32;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES    = 200;
    localparam int RANDOM_ITEMS   = 1150;

    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum int {
        FILL_SMALL,
        FILL_PLANTED,
        FILL_FULL,
        FILL_EDGE
    } fill_mode_t;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] mid;
        logic [DATA_W-1:0] high;
        logic              done;
        logic              ovf;
    } triplet_res_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] element;
    logic                     res_valid;
    logic                     res_ready;
    logic                     found;
    logic signed [DATA_W-1:0] low_value;
    logic signed [DATA_W-1:0] mid_value;
    logic signed [DATA_W-1:0] high_value;
    logic                     done_res;
    logic                     overflowed;

    // predictor state
    longint sorted_vals [STORE_DEPTH];
    int     val_count;
    int     scan_first;
    int     scan_left;
    int     scan_right;
    phase_t scan_state;
    logic   load_dropped;

    triplet_res_t pending_triplets [$];
    triplet_res_t want;

    int  errors        = 0;
    int  useful_items  = 0;
    int  results_seen  = 0;
    int  hits_seen     = 0;
    int  done_seen     = 0;
    int  ovf_seen      = 0;
    int  stall_cycles  = 0;
    int  rx_hold_left  = 0;
    int  rx_gap_left   = 0;
    bit  idle_on       = 1'b0;

    zero_sum_triplet_finder_top #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .kind       (kind),
        .element    (element),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .found      (found),
        .low_value  (low_value),
        .mid_value  (mid_value),
        .high_value (high_value),
        .done_res   (done_res),
        .overflowed (overflowed)
    );

    always #5 clk = ~clk;

    function automatic void rewind_scan();
        scan_state = PH_IDLE;
        scan_first = 0;
        scan_left  = 1;
        scan_right = 0;
    endfunction

    function automatic void insert_sorted(longint v);
        int pos;
        if (val_count >= STORE_DEPTH) begin
            load_dropped = 1'b1;
            return;
        end
        pos = val_count;
        while (pos > 0 && sorted_vals[pos-1] > v) begin
            sorted_vals[pos] = sorted_vals[pos-1];
            pos--;
        end
        sorted_vals[pos] = v;
        val_count++;
    endfunction

    // resumes the two-pointer scan until the next unique zero-sum triple or exhaustion
    function automatic triplet_res_t find_next_triplet();
        triplet_res_t r;
        longint       sum;
        bit           searching;
        r      = '0;
        r.done = 1'b1;
        r.ovf  = load_dropped;
        searching = (scan_state != PH_DONE);
        if (scan_state == PH_IDLE) begin
            scan_first = 0;
            scan_left  = 1;
            scan_right = val_count - 1;
            scan_state = PH_SCAN;
        end
        while (searching) begin
            if (scan_left < scan_right) begin
                sum = sorted_vals[scan_first] + sorted_vals[scan_left]
                    + sorted_vals[scan_right];
                if (sum < 0) begin
                    scan_left++;
                end else if (sum > 0) begin
                    scan_right--;
                end else begin
                    r.found = 1'b1;
                    r.done  = 1'b0;
                    r.low   = sorted_vals[scan_first][DATA_W-1:0];
                    r.mid   = sorted_vals[scan_left][DATA_W-1:0];
                    r.high  = sorted_vals[scan_right][DATA_W-1:0];
                    scan_left++;
                    scan_right--;
                    while (scan_left < scan_right &&
                           sorted_vals[scan_left] == sorted_vals[scan_left-1])
                        scan_left++;
                    while (scan_left < scan_right &&
                           sorted_vals[scan_right] == sorted_vals[scan_right+1])
                        scan_right--;
                    searching = 1'b0;
                end
            end else begin
                scan_first++;
                while (scan_first < val_count &&
                       sorted_vals[scan_first] == sorted_vals[scan_first-1])
                    scan_first++;
                if (scan_first >= val_count - 2) begin
                    scan_state = PH_DONE;
                    searching  = 1'b0;
                end else begin
                    scan_left  = scan_first + 1;
                    scan_right = val_count - 1;
                end
            end
        end
        return r;
    endfunction

    function automatic void predict_transaction(logic [KIND_W-1:0] k,
                                                logic signed [DATA_W-1:0] v);
        triplet_res_t nxt;
        case (k)
            KIND_CLEAR: begin
                val_count    = 0;
                load_dropped = 1'b0;
                rewind_scan();
            end
            KIND_LOAD: begin
                insert_sorted(longint'(v));
                rewind_scan();
            end
            KIND_NEXT: begin
                nxt = find_next_triplet();
                pending_triplets = {pending_triplets, nxt};
            end
            default: ;
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if (!idle_on || $urandom_range(0, 2) != 0)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 120);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(fill_mode_t mode, int span);
        case (mode)
            FILL_FULL: return $urandom;
            FILL_EDGE: begin
                case ($urandom_range(0, 7))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return VAL_MIN + 1;
                    3: return VAL_MAX - 1;
                    4: return 0;
                    5: return 1;
                    6: return -1;
                    default: return 2;
                endcase
            end
            default: return int'($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    task automatic send_item(logic [KIND_W-1:0] k, logic signed [DATA_W-1:0] v);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        kind      = k;
        element   = v;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_transaction(k, v);
        if (k != KIND_NOP)
            useful_items++;
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        req_valid = 1'b0;
        while (pending_triplets.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(string what, logic [DATA_W-1:0] exp_v,
                               logic [DATA_W-1:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, what, exp_v, got_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            results_seen++;
            hits_seen += found;
            done_seen += done_res;
            ovf_seen  += overflowed;
            if (pending_triplets.size() == 0) begin
                $display("%0t: result transaction with nothing expected", $time);
                errors++;
            end else begin
                want = pending_triplets.pop_front();
                check_field("found", want.found, found);
                check_field("low_value", want.low, low_value);
                check_field("mid_value", want.mid, mid_value);
                check_field("high_value", want.high, high_value);
                check_field("done_res", want.done, done_res);
                check_field("overflowed", want.ovf, overflowed);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // result receiver
    initial begin
        res_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (rx_hold_left == 0 && rx_gap_left == 0)
                rx_gap_left = gap_len();
            if (rx_hold_left > 0) begin
                res_ready = 1'b0;
                rx_hold_left--;
            end else if (rx_gap_left > 0) begin
                res_ready = 1'b0;
                rx_gap_left--;
            end else begin
                res_ready = 1'b1;
            end
        end
    end

    task automatic test_directed_cases();
        idle_on = 1'b0;
        send_item(KIND_NEXT, 0);            // empty store
        send_item(KIND_CLEAR, -1);
        send_item(KIND_LOAD, 7);
        send_item(KIND_NEXT, 0);            // single element
        send_item(KIND_LOAD, -7);
        send_item(KIND_LOAD, 0);
        send_item(KIND_NEXT, 0);
        send_item(KIND_NOP, VAL_MIN);
        send_item(KIND_NEXT, 0);            // exhausted
        send_item(KIND_NEXT, 0);            // stays exhausted
        send_item(KIND_LOAD, 0);            // load restarts the scan
        send_item(KIND_NEXT, 0);
        send_item(KIND_CLEAR, 0);
        // min + 1 + max is zero; max + max + 2 only wraps to zero
        send_item(KIND_LOAD, VAL_MAX);
        send_item(KIND_LOAD, VAL_MIN);
        send_item(KIND_LOAD, 1);
        send_item(KIND_LOAD, VAL_MAX);
        send_item(KIND_LOAD, 2);
        send_item(KIND_NEXT, 0);
        send_item(KIND_NEXT, 0);
        send_item(KIND_CLEAR, 0);
        repeat (4) send_item(KIND_LOAD, 0);
        send_item(KIND_NEXT, 0);
        send_item(KIND_NEXT, 0);
        wait_results_drained();
    endtask

    task automatic test_store_overflow();
        idle_on = 1'b1;
        send_item(KIND_CLEAR, 0);
        repeat (STORE_DEPTH + 2)
            send_item(KIND_LOAD, pick_value(FILL_SMALL, 6));
        repeat (4) send_item(KIND_NEXT, $urandom);
        send_item(KIND_LOAD, pick_value(FILL_SMALL, 6));
        send_item(KIND_NEXT, $urandom);
        send_item(KIND_CLEAR, $urandom);
        send_item(KIND_NEXT, $urandom);
        wait_results_drained();
    endtask

    // receiver holds off while requests keep coming, then the sender waits for all results
    task automatic test_result_backpressure();
        idle_on = 1'b0;
        rx_hold_left = RX_HOLD_CYCLES;
        send_item(KIND_CLEAR, 0);
        for (int v = -5; v <= 5; v++)
            send_item(KIND_LOAD, v);
        repeat (6) send_item(KIND_NEXT, $urandom);
        send_item(KIND_LOAD, 9);
        repeat (3) send_item(KIND_NEXT, $urandom);
        wait_results_drained();
        send_item(KIND_NEXT, $urandom);
        wait_results_drained();
    endtask

    task automatic test_random_sets(int target);
        int                       set_size;
        int                       span;
        int                       pick;
        fill_mode_t               mode;
        logic signed [DATA_W-1:0] trio [3];
        while (useful_items < target) begin
            idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 7) != 0)
                send_item(KIND_CLEAR, $urandom);
            pick = $urandom_range(0, 19);
            if (pick < 2)
                set_size = $urandom_range(0, 2);
            else if (pick < 16)
                set_size = $urandom_range(3, 10);
            else if (pick < 19)
                set_size = $urandom_range(11, 30);
            else
                set_size = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
            pick = $urandom_range(0, 9);
            mode = (pick < 5) ? FILL_SMALL : (pick < 7) ? FILL_PLANTED :
                   (pick < 8) ? FILL_FULL : (pick < 9) ? FILL_EDGE : FILL_SMALL;
            span = $urandom_range(1, 12);
            for (int i = 0; i < set_size; i++) begin
                if (mode == FILL_PLANTED) begin
                    // groups of three that sum to zero, with large magnitudes
                    if (i % 3 == 0) begin
                        trio[0] = $signed($urandom) >>> 1;
                        trio[1] = $signed($urandom) >>> 2;
                        trio[2] = -(trio[0] + trio[1]);
                    end
                    send_item(KIND_LOAD, trio[i % 3]);
                end else begin
                    send_item(KIND_LOAD, pick_value(mode, span));
                end
                if ($urandom_range(0, 19) == 0)
                    send_item(KIND_NOP, $urandom);
            end
            while (scan_state != PH_DONE) begin
                send_item(KIND_NEXT, $urandom);
                if ($urandom_range(0, 24) == 0)
                    send_item(KIND_LOAD, pick_value(mode == FILL_PLANTED ? FILL_SMALL : mode,
                                                    span));
                if ($urandom_range(0, 29) == 0)
                    send_item(KIND_NOP, $urandom);
            end
            repeat ($urandom_range(0, 2)) send_item(KIND_NEXT, $urandom);
        end
        wait_results_drained();
    endtask

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        kind      = KIND_CLEAR;
        element   = '0;
        val_count = 0;
        load_dropped = 1'b0;
        rewind_scan();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_store_overflow();
        test_result_backpressure();
        test_random_sets(RANDOM_ITEMS);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_triplets.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_triplets.size());
            errors++;
        end
        $display("run covered %0d transactions on the request side and %0d results",
                 useful_items, results_seen);
        $display("  %0d triplets found, %0d done answers, %0d with the dropped-load flag, %0d errors",
                 hits_seen, done_seen, ovf_seen, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/zstf_pkg.sv
hw/rtl/zstf_ctrl.sv
hw/rtl/zstf_datapath.sv
hw/rtl/zero_sum_triplet_finder_top.sv
dv/tb_zero_sum_triplet_finder_top.sv
